### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: label, clock, reset, property, message.
`define SPS_ASSERT_CR(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Short form on the block's own clock and synchronous reset.
`define SPS_ASSERT(lbl, prop, msg) \
   `SPS_ASSERT_CR(lbl, clock, reset, prop, msg)

`endif

### rtl/sps_pkg.sv
package sps_pkg;

   // Field widths
   localparam int MODE_W = 2;
   localparam int ROW_W  = 6;
   localparam int KIND_W = 3;
   localparam int CSR_W  = 7;

   // Storage defaults
   localparam int MAX_NODES_DEFAULT = 64;
   localparam logic [CSR_W-1:0] NODE_COUNT_RESET = 7'd64;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_NEIGHBOUR = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LOADED    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RANGE     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEARED   = 3'd4;

   // Classified operation handed to the back end
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_DIAG,
      OP_READ,
      OP_CLEAR,
      OP_RANGE
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] col;
   } cmd_type;

endpackage

### rtl/sps_front.sv
module sps_front #(
   parameter int MAX_NODES = sps_pkg::MAX_NODES_DEFAULT,
   localparam int CNT_W = $clog2(MAX_NODES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        q_full,
   input  logic [sps_pkg::MODE_W-1:0]  mode,
   input  logic [sps_pkg::ROW_W-1:0]   row_index,
   input  logic [sps_pkg::ROW_W-1:0]   col_index,
   input  logic                        csr_wr_en,
   input  logic [sps_pkg::CSR_W-1:0]   csr_wr_data,
   output logic                        push,
   output sps_pkg::cmd_type            push_cmd,
   output logic [CNT_W-1:0]            eff_count
);

   logic [sps_pkg::CSR_W-1:0] node_count_ff;
   logic                      row_oor;
   logic                      col_oor;

   // node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= sps_pkg::NODE_COUNT_RESET;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // saturate to storage size
   assign eff_count = (32'(node_count_ff) < MAX_NODES) ? CNT_W'(node_count_ff)
                                                       : CNT_W'(MAX_NODES);

   assign row_oor = 32'(row_index) >= 32'(eff_count);
   assign col_oor = 32'(col_index) >= 32'(eff_count);

   // accept and classify
   assign push = start && !q_full;

   always_comb begin
      push_cmd.row = row_index;
      push_cmd.col = col_index;
      unique case (mode)
         sps_pkg::MODE_LOAD: begin
            if (row_oor || col_oor) begin
               push_cmd.op = sps_pkg::OP_RANGE;
            end else if (row_index == col_index) begin
               push_cmd.op = sps_pkg::OP_DIAG;
            end else begin
               push_cmd.op = sps_pkg::OP_LOAD;
            end
         end
         sps_pkg::MODE_READ: begin
            push_cmd.op = row_oor ? sps_pkg::OP_RANGE : sps_pkg::OP_READ;
         end
         sps_pkg::MODE_CLEAR: begin
            push_cmd.op = sps_pkg::OP_CLEAR;
         end
         default: begin
            push_cmd.op = sps_pkg::OP_RANGE;
         end
      endcase
   end

endmodule

### rtl/sps_queue.sv
`include "assert_macros.svh"

module sps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sps_pkg::cmd_type push_cmd,
   input  logic             pop,
   output sps_pkg::cmd_type pop_cmd,
   output logic             empty,
   output logic             full
);

   sps_pkg::cmd_type                     slots_ff [sps_pkg::QUEUE_DEPTH];
   logic [sps_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff;
   logic [sps_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff;
   logic [sps_pkg::QUEUE_CNT_W-1:0]      count_ff;

   assign empty   = count_ff == '0;
   assign full    = count_ff == sps_pkg::QUEUE_CNT_W'(sps_pkg::QUEUE_DEPTH);
   assign pop_cmd = slots_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `SPS_ASSERT(a_no_overflow, push |-> !full, "queue push while full")
   `SPS_ASSERT(a_no_underflow, pop |-> !empty, "queue pop while empty")

endmodule

### rtl/sps_back.sv
`include "assert_macros.svh"

module sps_back #(
   parameter int MAX_NODES = sps_pkg::MAX_NODES_DEFAULT,
   localparam int CNT_W = $clog2(MAX_NODES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  sps_pkg::cmd_type            q_cmd,
   input  logic [CNT_W-1:0]            eff_count,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic [sps_pkg::KIND_W-1:0]  rsp_kind,
   output logic [sps_pkg::ROW_W-1:0]   rsp_row_out,
   output logic [sps_pkg::ROW_W-1:0]   rsp_neighbour,
   output logic                        rsp_last
);

   localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int ROW_W  = sps_pkg::ROW_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD_A,
      S_LOAD_B,
      S_SCAN_WAIT,
      S_SCAN
   } state_type;

   // adjacency store, one word per row
   logic [MAX_NODES-1:0] mem [MAX_NODES];
   logic [MAX_NODES-1:0] row_valid_ff;
   logic [MAX_NODES-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [MAX_NODES-1:0] wr_data;
   logic                 clr_en;

   state_type            state_ff,  state_in;
   sps_pkg::cmd_type     cmd_ff,    cmd_in;
   logic [MAX_NODES-1:0] scan_ff,   scan_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [sps_pkg::KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [ROW_W-1:0]     rsp_nb_ff,  rsp_nb_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [MAX_NODES-1:0] row_word;
   logic [MAX_NODES-1:0] limit_mask;
   logic [MAX_NODES-1:0] masked_word;
   logic [MAX_NODES-1:0] low_bit;
   logic [MAX_NODES-1:0] scan_rest;
   logic [ADDR_W-1:0]    low_idx;

   // unwritten rows read as zero
   assign row_word    = rd_valid_ff ? rd_data_ff : '0;
   assign limit_mask  = ~({MAX_NODES{1'b1}} << eff_count);
   assign masked_word = row_word & limit_mask & ~(MAX_NODES'(1) << cmd_ff.row);

   // lowest remaining neighbour
   assign low_bit   = scan_ff & (~scan_ff + MAX_NODES'(1));
   assign scan_rest = scan_ff & (scan_ff - MAX_NODES'(1));

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | ADDR_W'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      scan_in      = scan_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_nb_in    = rsp_nb_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(cmd_ff.row);
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(cmd_ff.row);
      wr_data      = row_word | (MAX_NODES'(1) << cmd_ff.col);
      clr_en       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop        = 1'b1;
               cmd_in     = q_cmd;
               rsp_row_in = q_cmd.row;
               rsp_nb_in  = '0;
               rsp_last_in = 1'b1;
               unique case (q_cmd.op)
                  sps_pkg::OP_LOAD: begin
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(q_cmd.row);
                     state_in = S_LOAD_A;
                  end
                  sps_pkg::OP_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(q_cmd.row);
                     state_in = S_SCAN_WAIT;
                  end
                  sps_pkg::OP_DIAG: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = sps_pkg::KIND_LOADED;
                  end
                  sps_pkg::OP_CLEAR: begin
                     clr_en       = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = sps_pkg::KIND_CLEARED;
                     rsp_row_in   = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = sps_pkg::KIND_RANGE;
                  end
               endcase
            end
         end
         S_LOAD_A: begin
            // set (row, col), fetch the mirrored row
            wr_en    = 1'b1;
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(cmd_ff.col);
            state_in = S_LOAD_B;
         end
         S_LOAD_B: begin
            // set (col, row)
            wr_en        = 1'b1;
            wr_addr      = ADDR_W'(cmd_ff.col);
            wr_data      = row_word | (MAX_NODES'(1) << cmd_ff.row);
            rsp_valid_in = 1'b1;
            rsp_kind_in  = sps_pkg::KIND_LOADED;
            state_in     = S_IDLE;
         end
         S_SCAN_WAIT: begin
            if (masked_word == '0) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = sps_pkg::KIND_EMPTY;
               state_in     = S_IDLE;
            end else begin
               scan_in  = masked_word;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = sps_pkg::KIND_NEIGHBOUR;
            rsp_nb_in    = ROW_W'(low_idx);
            rsp_last_in  = scan_rest == '0;
            scan_in      = scan_rest;
            if (scan_rest == '0) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      scan_ff     <= scan_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_nb_ff   <= rsp_nb_in;
      rsp_last_ff <= rsp_last_in;
   end

   // row memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // per-row valid bits; clear empties the store at once
   always_ff @(posedge clock) begin
      if (reset || clr_en) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_row_out   = rsp_row_ff;
   assign rsp_neighbour = rsp_nb_ff;
   assign rsp_last      = rsp_last_ff;

   `SPS_ASSERT(a_scan_nonzero, (state_ff == S_SCAN) |-> (scan_ff != '0), "scan on empty word")
   `SPS_ASSERT(a_load_order, (state_ff == S_LOAD_B) |-> ($past(state_ff) == S_LOAD_A),
      "second load write without first")
   `SPS_ASSERT(a_pop_idle, pop |-> (state_ff == S_IDLE), "queue popped while busy")

endmodule

### rtl/sparse_pattern_symmetrizer.sv
// Channel   Handshake                Payload
// request   start / busy             req_mode, req_row_index, req_col_index
// response  rsp_valid (strobe)       rsp_kind, rsp_row_out, rsp_neighbour, rsp_last
// config    csr_wr_en                csr_wr_data (node count)
//
// A transaction is taken when start is high and busy is low; a two-entry
// command queue decouples the classifier from the row-memory sequencer.
// Load: two read-modify-writes on the row memory, (row, col) then (col, row).
// Read: fetch and mask the row, then one neighbour per cycle.
// Clear, diagonal load and out-of-range respond from the idle state; clear drops all row valid
// bits at once. Synchronous active-high reset, no clearing pass.
// Responses are one-cycle strobes; the receiver cannot stall them.
module sparse_pattern_symmetrizer #(
   parameter int MAX_NODES = sps_pkg::MAX_NODES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [sps_pkg::MODE_W-1:0]  req_mode,
   input  logic [sps_pkg::ROW_W-1:0]   req_row_index,
   input  logic [sps_pkg::ROW_W-1:0]   req_col_index,
   input  logic                        csr_wr_en,
   input  logic [sps_pkg::CSR_W-1:0]   csr_wr_data,
   output logic                        rsp_valid,
   output logic [sps_pkg::KIND_W-1:0]  rsp_kind,
   output logic [sps_pkg::ROW_W-1:0]   rsp_row_out,
   output logic [sps_pkg::ROW_W-1:0]   rsp_neighbour,
   output logic                        rsp_last
);

   localparam int CNT_W = $clog2(MAX_NODES + 1);

   logic             push;
   logic             pop;
   logic             q_empty;
   logic             q_full;
   sps_pkg::cmd_type push_cmd;
   sps_pkg::cmd_type pop_cmd;
   logic [CNT_W-1:0] eff_count;

   assign busy = q_full;

   // classify requests
   sps_front #(.MAX_NODES(MAX_NODES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .q_full      (q_full),
      .mode        (req_mode),
      .row_index   (req_row_index),
      .col_index   (req_col_index),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_cmd    (push_cmd),
      .eff_count   (eff_count)
   );

   // command queue
   sps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   // execute against the row store
   sps_back #(.MAX_NODES(MAX_NODES)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_cmd         (pop_cmd),
      .eff_count     (eff_count),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_row_out   (rsp_row_out),
      .rsp_neighbour (rsp_neighbour),
      .rsp_last      (rsp_last)
   );

endmodule
